// File: rtl/ttok_pkg.sv
// ----------------------------------------------------------------------------
// ttok_pkg: shared types and byte codes of the text tokenizer
// Byte classes used by the decoder and the per-byte action word that the
// decoder hands to the control sequencer in the top level.
// ----------------------------------------------------------------------------
package ttok_pkg;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] PUNCT1_LO  = 8'h21;
	localparam logic [7:0] PUNCT1_HI  = 8'h2F;
	localparam logic [7:0] PUNCT2_LO  = 8'h3A;
	localparam logic [7:0] PUNCT2_HI  = 8'h40;
	localparam logic [7:0] PUNCT3_LO  = 8'h5B;
	localparam logic [7:0] PUNCT3_HI  = 8'h60;
	localparam logic [7:0] PUNCT4_LO  = 8'h7B;
	localparam logic [7:0] PUNCT4_HI  = 8'h7E;

	// What one input byte does to the token buffer, in this order:
	// append_pre, flush, single, append_post.
	typedef struct packed {
		logic append_pre;   // append the byte before any flush
		logic flush;        // emit the buffered token
		logic single;       // emit the byte as a one-character token
		logic append_post;  // start a new token with the byte after the flush
		logic in_str_nx;    // string mode after this byte
		logic esc_nx;       // escape pending after this byte
	} act_t;

endpackage

// File: rtl/ttok_decode.sv
// ----------------------------------------------------------------------------
// ttok_decode: byte classifier of the text tokenizer
// Maps the current byte, its lookahead and the string state to an action word.
// ----------------------------------------------------------------------------
module ttok_decode (
	input  logic [7:0]     ch,
	input  logic [7:0]     next_byte,
	input  logic           is_last,
	input  logic           in_str,
	input  logic           esc,
	input  logic [7:0]     prev_byte,
	input  logic           strings_on,
	output ttok_pkg::act_t act
);

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ttok_pkg::CH_ZERO) && (c <= ttok_pkg::CH_NINE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return ((c >= ttok_pkg::CH_TAB) && (c <= ttok_pkg::CH_CR)) || (c == ttok_pkg::CH_SPACE);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return ((c >= ttok_pkg::PUNCT1_LO) && (c <= ttok_pkg::PUNCT1_HI)) ||
		       ((c >= ttok_pkg::PUNCT2_LO) && (c <= ttok_pkg::PUNCT2_HI)) ||
		       ((c >= ttok_pkg::PUNCT3_LO) && (c <= ttok_pkg::PUNCT3_HI)) ||
		       ((c >= ttok_pkg::PUNCT4_LO) && (c <= ttok_pkg::PUNCT4_HI));
	endfunction

	always_comb begin
		act = '0;
		act.in_str_nx = in_str;
		act.esc_nx    = esc;
		if (in_str) begin
			if (esc) begin
				act.append_pre = 1'b1;
				act.esc_nx     = 1'b0;
			end else if (ch == ttok_pkg::CH_BSLASH) begin
				act.esc_nx = 1'b1;
			end else begin
				act.append_pre = 1'b1;
				if (ch == ttok_pkg::CH_QUOTE) begin
					act.flush     = 1'b1;
					act.in_str_nx = 1'b0;
				end
			end
		end else if ((ch == ttok_pkg::CH_QUOTE) && strings_on) begin
			// open a string; on the final byte the lone quote leaves at once
			act.flush       = 1'b1;
			act.single      = is_last;
			act.append_post = !is_last;
			act.in_str_nx   = 1'b1;
			act.esc_nx      = 1'b0;
		end else if (is_space(ch)) begin
			act.flush = 1'b1;
		end else if (ch == ttok_pkg::CH_DOT) begin
			act.append_pre = is_digit(prev_byte);
			act.flush      = !is_digit(prev_byte);
			act.single     = !is_digit(prev_byte);
		end else if (ch == ttok_pkg::CH_MINUS) begin
			act.append_pre = !is_last && is_digit(next_byte);
			act.flush      = is_last || !is_digit(next_byte);
			act.single     = is_last || !is_digit(next_byte);
		end else if (is_punct(ch)) begin
			act.flush  = 1'b1;
			act.single = 1'b1;
		end else begin
			act.append_pre = 1'b1;
		end
		// end of stream: flush whatever is left and drop string mode
		if (is_last) begin
			act.flush     = 1'b1;
			act.in_str_nx = 1'b0;
			act.esc_nx    = 1'b0;
		end
	end

endmodule

// File: rtl/text_tokenizer_with_quoted_strings_unit.sv
// ----------------------------------------------------------------------------
// text_tokenizer_with_quoted_strings_unit: byte stream tokenizer
// Splits bytes into tokens and streams each token out one character at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one byte per transfer, with its
//   lookahead byte and an end-of-stream mark. Output channel
//   (out_valid/out_ready): one token character per transfer, tagged with
//   token end, last-of-byte mark, line, column and truncation.
//   Config channel (cfg_valid/cfg_ready, always ready): writes process_strings;
//   write it only while the unit is idle.
// Timing:
//   A byte that flushes nothing leaves the unit idle, ready for the next
//   byte. A flush reads the buffer through its registered read port, one
//   read (ST_RD) and one output load (ST_WAIT) per character, then loads a
//   following punctuation token in ST_SINGLE. A lone punctuation token
//   goes straight from ST_SINGLE into the output register.
// Reset: all control state clears, process_strings returns to 1, no memory
//   clearing pass is needed since only written entries are ever read.
// Stall: the output register holds its character while out_ready is low and
//   the flush sequence waits; once the last character of a byte is loaded the
//   unit takes the next byte even if that character is still waiting.
// ----------------------------------------------------------------------------
module text_tokenizer_with_quoted_strings_unit #(
	parameter int TOKEN_MAX    = 32,
	parameter int COUNTER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// input bytes
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic [7:0]  next_byte,
	input  logic        is_last,
	// token characters
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  token_char,
	output logic        token_end,
	output logic        run_last,
	output logic [15:0] line_no,
	output logic [15:0] column_no,
	output logic        truncated
);

	localparam int LW = $clog2(TOKEN_MAX + 1);  // token length
	localparam int IW = $clog2(TOKEN_MAX);      // buffer index

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RD     = 4'b0010,
		ST_WAIT   = 4'b0100,
		ST_SINGLE = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [LW-1:0]           len_q;
	logic                    ovf_q;
	logic                    in_str_q;
	logic                    esc_q;
	logic [7:0]              prev_q;
	logic [COUNTER_BITS-1:0] line_q;
	logic [COUNTER_BITS-1:0] col_q;
	logic                    strings_on_q;
	logic [IW-1:0]           idx_q;
	logic                    pend_single_q;
	logic                    pend_app_q;
	logic [7:0]              ch_q;
	logic [15:0]             item_line_q;
	logic [15:0]             item_col_q;

	logic                    out_valid_q;
	logic [7:0]              out_char_q;
	logic                    out_end_q;
	logic                    out_last_q;
	logic [15:0]             out_line_q;
	logic [15:0]             out_col_q;
	logic                    out_trunc_q;

	// token buffer memory, one write and one registered read port
	logic [7:0]              tok_mem_q [TOKEN_MAX];
	logic [7:0]              rd_data_q;
	logic                    mem_wr;
	logic [IW-1:0]           mem_wr_addr;
	logic [7:0]              mem_wr_data;
	logic                    mem_rd;

	ttok_pkg::act_t          act;
	logic                    in_xfer;
	logic                    out_free;
	logic                    has_room;
	logic [LW-1:0]           len_after;
	logic                    flush_last;

	ttok_decode u_decode (
		.ch         (ch),
		.next_byte  (next_byte),
		.is_last    (is_last),
		.in_str     (in_str_q),
		.esc        (esc_q),
		.prev_byte  (prev_q),
		.strings_on (strings_on_q),
		.act        (act)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign has_room  = (len_q < LW'(TOKEN_MAX));
	assign len_after = (act.append_pre && has_room) ? (len_q + LW'(1)) : len_q;
	assign flush_last = ((LW'(idx_q) + LW'(1)) == len_q);

	// memory port control: appends in idle, deferred append at end of a flush
	always_comb begin
		mem_wr      = 1'b0;
		mem_wr_addr = len_q[IW-1:0];
		mem_wr_data = ch;
		mem_rd      = (state_q == ST_RD);
		if (in_xfer) begin
			if (act.append_pre && has_room) begin
				mem_wr = 1'b1;
			end else if (act.append_post && (len_after == '0)) begin
				mem_wr      = 1'b1;
				mem_wr_addr = '0;
			end
		end else if ((state_q == ST_WAIT) && out_free && flush_last &&
		             !pend_single_q && pend_app_q) begin
			mem_wr      = 1'b1;
			mem_wr_addr = '0;
			mem_wr_data = ch_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			tok_mem_q[mem_wr_addr] <= mem_wr_data;
		end
		if (mem_rd) begin
			rd_data_q <= tok_mem_q[idx_q];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strings_on_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			strings_on_q <= cfg_data;
		end
	end

	// stream position and string state, updated once per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_str_q <= 1'b0;
			esc_q    <= 1'b0;
			prev_q   <= '0;
			line_q   <= '0;
			col_q    <= '0;
		end else if (in_xfer) begin
			in_str_q <= act.in_str_nx;
			esc_q    <= act.esc_nx;
			if (is_last) begin
				// next byte starts a fresh stream
				prev_q <= '0;
				line_q <= '0;
				col_q  <= '0;
			end else begin
				prev_q <= ch;
				if (ch == ttok_pkg::CH_NL) begin
					if (line_q != '1) begin
						line_q <= line_q + COUNTER_BITS'(1);
					end
					col_q <= '0;
				end else if (col_q != '1) begin
					col_q <= col_q + COUNTER_BITS'(1);
				end
			end
		end
	end

	// per-byte payload held through the flush sequence
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_q        <= ch;
			item_line_q <= 16'(line_q);
			item_col_q  <= 16'(col_q);
		end
	end

	// flush sequencer and token length bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			len_q         <= '0;
			ovf_q         <= 1'b0;
			idx_q         <= '0;
			pend_single_q <= 1'b0;
			pend_app_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						pend_single_q <= act.single;
						pend_app_q    <= act.append_post;
						idx_q         <= '0;
						if (act.append_pre && !has_room) begin
							ovf_q <= 1'b1;
						end
						if (act.flush && (len_after != '0)) begin
							len_q   <= len_after;
							state_q <= ST_RD;
						end else if (act.flush) begin
							// nothing buffered: skip straight past the flush
							ovf_q <= 1'b0;
							len_q <= act.append_post ? LW'(1) : '0;
							if (act.single) begin
								state_q <= ST_SINGLE;
							end
						end else begin
							len_q <= len_after;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_free) begin
						if (flush_last) begin
							ovf_q <= 1'b0;
							if (pend_single_q) begin
								len_q   <= '0;
								state_q <= ST_SINGLE;
							end else begin
								// open quote lands in the freed buffer
								len_q   <= pend_app_q ? LW'(1) : '0;
								state_q <= ST_IDLE;
							end
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_SINGLE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: load a character, hold it until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_WAIT || state_q == ST_SINGLE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_WAIT) begin
				out_char_q  <= rd_data_q;
				out_end_q   <= flush_last;
				out_last_q  <= flush_last && !pend_single_q;
				out_trunc_q <= ovf_q;
				out_line_q  <= item_line_q;
				out_col_q   <= item_col_q;
			end else if (state_q == ST_SINGLE) begin
				out_char_q  <= ch_q;
				out_end_q   <= 1'b1;
				out_last_q  <= 1'b1;
				out_trunc_q <= 1'b0;
				out_line_q  <= item_line_q;
				out_col_q   <= item_col_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign token_char = out_char_q;
	assign token_end  = out_end_q;
	assign run_last   = out_last_q;
	assign line_no    = out_line_q;
	assign column_no  = out_col_q;
	assign truncated  = out_trunc_q;

	// the buffer port never reads and writes in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_rd && mem_wr))
		else $error("token buffer read and write collide");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(TOKEN_MAX))
		else $error("token length beyond buffer size");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LW'(TOKEN_MAX)))
		else $error("overflow flag set on a token that is not full");

	a_esc_in_str: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> in_str_q)
		else $error("escape pending outside a string");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && is_last) |=> (line_q == '0) && (col_q == '0) && !in_str_q)
		else $error("stream state not cleared after final byte");

endmodule
